// ===== rtl/djs_pkg.sv =====
// ----------------------------------------------------------------------------
// djs_pkg: deadline job scheduler shared types and codes
// entry layout, command kinds, result status codes and sequencer states
// ----------------------------------------------------------------------------
package djs_pkg;

	localparam int TimeW    = 64;
	localparam int LimitCap = 16;

	typedef enum logic [2:0] {
		KIND_ADD_ONE  = 3'd0,
		KIND_ADD_PER  = 3'd1,
		KIND_CANCEL   = 3'd2,
		KIND_DISPATCH = 3'd3,
		KIND_QUERY    = 3'd4
	} kind_t;

	typedef enum logic [3:0] {
		STS_OK        = 4'd0,
		STS_FULL      = 4'd1,
		STS_DUP       = 4'd2,
		STS_BAD_PER   = 4'd3,
		STS_CANCELLED = 4'd4,
		STS_NOT_FOUND = 4'd5,
		STS_EVENT     = 4'd6,
		STS_DONE      = 4'd7,
		STS_DEADLINE  = 4'd8,
		STS_EMPTY     = 4'd9
	} status_t;

	localparam logic [1:0] MISS_SKIP = 2'd0;

	typedef struct packed {
		logic [15:0] key;
		logic [31:0] owner;
		logic [15:0] ev;
		logic [63:0] deadline;
		logic [63:0] anchor;
		logic [63:0] period;
		logic [31:0] gen;
		logic [1:0]  miss;
		logic [1:0]  prio;
		logic        pending;
	} entry_t;

	typedef enum logic [15:0] {
		S_IDLE    = 16'h0001,
		S_DECODE  = 16'h0002,
		S_SCAN_RD = 16'h0004,
		S_SCAN_CK = 16'h0008,
		S_DV_INIT = 16'h0010,
		S_DV_RUN  = 16'h0020,
		S_DV_FIN1 = 16'h0040,
		S_DV_FIN2 = 16'h0080,
		S_ADD_WR  = 16'h0100,
		S_CP_RD   = 16'h0200,
		S_CP_WR   = 16'h0400,
		S_DS_RD   = 16'h0800,
		S_DS_CK   = 16'h1000,
		S_POST    = 16'h2000,
		S_QY_RD   = 16'h4000,
		S_QY_CK   = 16'h8000
	} state_t;

endpackage

// ===== rtl/deadline_job_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// deadline_job_scheduler_unit: ordered compacting table of timed jobs
// add, cancel, dispatch and earliest-deadline query over one entry ram
// ----------------------------------------------------------------------------
// usage
//   a command beat is taken at a clock edge with start high and busy low;
//   busy drops in the cycle that shows the last result beat of the command
//   results come out at most one beat per cycle, marked by result_valid, with
//   last set on the final beat; the receiver cannot stall, so every beat is
//   shown for exactly one cycle; unused kinds give no beat
// command flow
//   a decode state, then each entry is visited as a ram address state and
//   then a check state; removing an entry shifts the later ones down, a read
//   then a write per entry; a result beat shows in the cycle after the step that made it
//   each periodic deadline comes from a shared bit-serial remainder unit:
//   64 steps between a setup state and the finish states S_DV_FIN1, S_DV_FIN2
//   a dispatch visits entries in turn and runs the remainder unit for each
//   posted periodic job, which makes it the longest command; unused kinds
//   go from decode straight back to idle
//   one command at a time: the next is taken in the cycle of the final beat
// reset
//   arst_n clears the fill count, so the table starts empty; the entry ram is
//   not cleared, only entries below the fill count are ever read
// ----------------------------------------------------------------------------
module deadline_job_scheduler_unit #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  kind,
	input  logic [15:0] job_key,
	input  logic [31:0] owner,
	input  logic [15:0] event_code,
	input  logic [63:0] time_value,
	input  logic [63:0] period,
	input  logic [31:0] gen_tag,
	input  logic [1:0]  miss_rule,
	input  logic [1:0]  prio,
	input  logic [63:0] now_time,
	input  logic [4:0]  event_limit,
	output logic        result_valid,
	output logic [3:0]  status,
	output logic [15:0] out_job_key,
	output logic [31:0] out_owner,
	output logic [15:0] out_event_code,
	output logic [1:0]  out_prio,
	output logic [31:0] out_gen_tag,
	output logic [63:0] out_time,
	output logic [4:0]  posted_count,
	output logic        last
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int EW = $bits(djs_pkg::entry_t);
	localparam logic [CW-1:0] DepthC = CW'(TABLE_DEPTH);

	// control registers
	djs_pkg::state_t state_q, state_d;
	logic [CW-1:0] total_q, total_d;    // live entries
	logic [CW-1:0] idx_q, idx_d;        // walk position
	logic [CW-1:0] jdx_q, jdx_d;        // compaction position
	logic [4:0]    posted_q, posted_d;
	logic [5:0]    cnt_q, cnt_d;        // remainder step count
	logic          result_valid_q;

	// latched command
	logic [2:0]  kind_q;
	logic [15:0] key_q;
	logic [31:0] owner_q;
	logic [15:0] ev_q;
	logic [63:0] tv_q;
	logic [63:0] per_q;
	logic [31:0] gen_q;
	logic [1:0]  miss_q;
	logic [1:0]  prio_q;
	logic [63:0] now_q;
	logic [4:0]  lim_q;

	// shared remainder unit
	logic [63:0] op_anchor_q, op_per_q, dvd_q, res_q, best_q, rem_q;
	logic [64:0] rem_sh;
	logic [64:0] sum_w;

	// output beat registers
	logic [3:0]  status_q;
	logic [15:0] okey_q, oev_q;
	logic [31:0] oown_q, ogen_q;
	logic [1:0]  oprio_q;
	logic [63:0] otime_q;
	logic [4:0]  ocnt_q;
	logic        olast_q;

	// entry ram
	logic          we, re;
	logic [AW-1:0] waddr, raddr;
	djs_pkg::entry_t wdata, cur;
	logic [EW-1:0] rdata_w;

	// sequencer decisions
	logic          emit, em_event, em_last;
	logic [3:0]    em_status;
	logic [63:0]   em_time;
	logic          dv_load, dv_from_entry, res_from_cur;
	logic [CW-1:0] idx_nx, jdx_nx;
	logic          due, key_hit;

	djs_ram #(
		.WIDTH (EW),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata_w)
	);

	assign cur     = djs_pkg::entry_t'(rdata_w);
	assign idx_nx  = idx_q + 1'b1;
	assign jdx_nx  = jdx_q + 1'b1;
	assign due     = (cur.deadline <= now_q);
	assign key_hit = (cur.key == key_q);

	// one restoring remainder step
	always_comb begin
		rem_sh = {rem_q, dvd_q[63]};
		if (rem_sh >= {1'b0, op_per_q}) begin
			rem_sh = rem_sh - {1'b0, op_per_q};
		end
	end

	// next anchored deadline, carry out means it ran past the time range
	assign sum_w = {1'b0, res_q} + {1'b0, op_per_q};

	// sequencer
	always_comb begin
		state_d       = state_q;
		total_d       = total_q;
		idx_d         = idx_q;
		jdx_d         = jdx_q;
		posted_d      = posted_q;
		cnt_d         = cnt_q;
		emit          = 1'b0;
		em_event      = 1'b0;
		em_last       = 1'b0;
		em_status     = djs_pkg::STS_OK;
		em_time       = '0;
		dv_load       = 1'b0;
		dv_from_entry = 1'b0;
		res_from_cur  = 1'b0;
		re            = 1'b0;
		raddr         = idx_q[AW-1:0];
		we            = 1'b0;
		waddr         = idx_q[AW-1:0];
		wdata         = cur;

		unique case (state_q)
			djs_pkg::S_IDLE: begin
				if (start) begin
					state_d  = djs_pkg::S_DECODE;
					idx_d    = '0;
					posted_d = '0;
				end
			end
			djs_pkg::S_DECODE: begin
				unique case (kind_q)
					djs_pkg::KIND_ADD_ONE, djs_pkg::KIND_ADD_PER: begin
						if (kind_q == djs_pkg::KIND_ADD_PER && per_q == '0) begin
							emit      = 1'b1;
							em_last   = 1'b1;
							em_status = djs_pkg::STS_BAD_PER;
							state_d   = djs_pkg::S_IDLE;
						end else if (total_q >= DepthC) begin
							emit      = 1'b1;
							em_last   = 1'b1;
							em_status = djs_pkg::STS_FULL;
							state_d   = djs_pkg::S_IDLE;
						end else begin
							state_d = djs_pkg::S_SCAN_RD;
						end
					end
					djs_pkg::KIND_CANCEL: state_d = djs_pkg::S_SCAN_RD;
					djs_pkg::KIND_DISPATCH: state_d = djs_pkg::S_DS_RD;
					djs_pkg::KIND_QUERY: begin
						if (total_q == '0) begin
							emit      = 1'b1;
							em_last   = 1'b1;
							em_status = djs_pkg::STS_EMPTY;
							state_d   = djs_pkg::S_IDLE;
						end else begin
							state_d = djs_pkg::S_QY_RD;
						end
					end
					default: state_d = djs_pkg::S_IDLE;
				endcase
			end
			djs_pkg::S_SCAN_RD: begin
				if (idx_q < total_q) begin
					re      = 1'b1;
					state_d = djs_pkg::S_SCAN_CK;
				end else if (kind_q == djs_pkg::KIND_CANCEL) begin
					emit      = 1'b1;
					em_last   = 1'b1;
					em_status = djs_pkg::STS_NOT_FOUND;
					state_d   = djs_pkg::S_IDLE;
				end else if (kind_q == djs_pkg::KIND_ADD_PER) begin
					dv_load = 1'b1;
					state_d = djs_pkg::S_DV_INIT;
				end else begin
					state_d = djs_pkg::S_ADD_WR;
				end
			end
			djs_pkg::S_SCAN_CK: begin
				if (!key_hit) begin
					idx_d   = idx_nx;
					state_d = djs_pkg::S_SCAN_RD;
				end else if (kind_q != djs_pkg::KIND_CANCEL) begin
					emit      = 1'b1;
					em_last   = 1'b1;
					em_status = djs_pkg::STS_DUP;
					state_d   = djs_pkg::S_IDLE;
				end else if (cur.gen == gen_q) begin
					jdx_d   = idx_q;
					state_d = djs_pkg::S_CP_RD;
				end else begin
					emit      = 1'b1;
					em_last   = 1'b1;
					em_status = djs_pkg::STS_NOT_FOUND;
					state_d   = djs_pkg::S_IDLE;
				end
			end
			djs_pkg::S_DV_INIT: begin
				cnt_d = '0;
				if (op_anchor_q > now_q) begin
					state_d = (kind_q == djs_pkg::KIND_DISPATCH) ?
						djs_pkg::S_POST : djs_pkg::S_ADD_WR;
				end else begin
					state_d = djs_pkg::S_DV_RUN;
				end
			end
			djs_pkg::S_DV_RUN: begin
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == 6'd63) begin
					state_d = djs_pkg::S_DV_FIN1;
				end
			end
			djs_pkg::S_DV_FIN1: state_d = djs_pkg::S_DV_FIN2;
			djs_pkg::S_DV_FIN2: begin
				state_d = (kind_q == djs_pkg::KIND_DISPATCH) ?
					djs_pkg::S_POST : djs_pkg::S_ADD_WR;
			end
			djs_pkg::S_ADD_WR: begin
				we             = 1'b1;
				waddr          = total_q[AW-1:0];
				wdata.key      = key_q;
				wdata.owner    = owner_q;
				wdata.ev       = ev_q;
				wdata.anchor   = tv_q;
				wdata.gen      = gen_q;
				wdata.prio     = prio_q;
				wdata.pending  = 1'b0;
				if (kind_q == djs_pkg::KIND_ADD_ONE) begin
					wdata.period   = '0;
					wdata.miss     = djs_pkg::MISS_SKIP;
					wdata.deadline = tv_q;
				end else begin
					wdata.period   = per_q;
					wdata.miss     = miss_q;
					wdata.deadline = res_q;
				end
				total_d   = total_q + 1'b1;
				emit      = 1'b1;
				em_last   = 1'b1;
				em_status = djs_pkg::STS_OK;
				state_d   = djs_pkg::S_IDLE;
			end
			djs_pkg::S_CP_RD: begin
				if (jdx_nx < total_q) begin
					re      = 1'b1;
					raddr   = jdx_nx[AW-1:0];
					state_d = djs_pkg::S_CP_WR;
				end else begin
					total_d = total_q - 1'b1;
					if (kind_q == djs_pkg::KIND_CANCEL) begin
						emit      = 1'b1;
						em_last   = 1'b1;
						em_status = djs_pkg::STS_CANCELLED;
						state_d   = djs_pkg::S_IDLE;
					end else begin
						state_d = djs_pkg::S_DS_RD;
					end
				end
			end
			djs_pkg::S_CP_WR: begin
				we      = 1'b1;
				waddr   = jdx_q[AW-1:0];
				jdx_d   = jdx_nx;
				state_d = djs_pkg::S_CP_RD;
			end
			djs_pkg::S_DS_RD: begin
				if (idx_q < total_q && posted_q < lim_q) begin
					re      = 1'b1;
					state_d = djs_pkg::S_DS_CK;
				end else begin
					emit      = 1'b1;
					em_last   = 1'b1;
					em_status = djs_pkg::STS_DONE;
					state_d   = djs_pkg::S_IDLE;
				end
			end
			djs_pkg::S_DS_CK: begin
				if (!due || (cur.pending && cur.miss != djs_pkg::MISS_SKIP)) begin
					idx_d   = idx_nx;
					state_d = djs_pkg::S_DS_RD;
				end else if (cur.pending && cur.period == '0) begin
					// stale one-shot job: drop it, walk resumes at same place
					jdx_d   = idx_q;
					state_d = djs_pkg::S_CP_RD;
				end else if (cur.period != '0) begin
					dv_load       = 1'b1;
					dv_from_entry = 1'b1;
					state_d       = djs_pkg::S_DV_INIT;
				end else begin
					res_from_cur = 1'b1;
					state_d      = djs_pkg::S_POST;
				end
			end
			djs_pkg::S_POST: begin
				we             = 1'b1;
				wdata.deadline = res_q;
				wdata.pending  = 1'b1;
				emit           = 1'b1;
				em_event       = 1'b1;
				em_status      = djs_pkg::STS_EVENT;
				em_time        = now_q;
				posted_d       = posted_q + 1'b1;
				idx_d          = idx_nx;
				state_d        = djs_pkg::S_DS_RD;
			end
			djs_pkg::S_QY_RD: begin
				if (idx_q < total_q) begin
					re      = 1'b1;
					state_d = djs_pkg::S_QY_CK;
				end else begin
					emit      = 1'b1;
					em_last   = 1'b1;
					em_status = djs_pkg::STS_DEADLINE;
					em_time   = best_q;
					state_d   = djs_pkg::S_IDLE;
				end
			end
			djs_pkg::S_QY_CK: begin
				idx_d   = idx_nx;
				state_d = djs_pkg::S_QY_RD;
			end
			default: state_d = djs_pkg::S_IDLE;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= djs_pkg::S_IDLE;
			total_q        <= '0;
			idx_q          <= '0;
			jdx_q          <= '0;
			posted_q       <= '0;
			cnt_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q        <= state_d;
			total_q        <= total_d;
			idx_q          <= idx_d;
			jdx_q          <= jdx_d;
			posted_q       <= posted_d;
			cnt_q          <= cnt_d;
			result_valid_q <= emit;
		end
	end

	// payload: command latch, remainder unit, running minimum, result beat
	always_ff @(posedge clk) begin
		if (state_q == djs_pkg::S_IDLE && start) begin
			kind_q  <= kind;
			key_q   <= job_key;
			owner_q <= owner;
			ev_q    <= event_code;
			tv_q    <= time_value;
			per_q   <= period;
			gen_q   <= gen_tag;
			miss_q  <= miss_rule;
			prio_q  <= prio;
			now_q   <= now_time;
			lim_q   <= (event_limit > 5'(djs_pkg::LimitCap)) ?
				5'(djs_pkg::LimitCap) : event_limit;
		end
		if (dv_load) begin
			op_anchor_q <= dv_from_entry ? cur.anchor : tv_q;
			op_per_q    <= dv_from_entry ? cur.period : per_q;
		end
		if (res_from_cur) begin
			res_q <= cur.deadline;
		end
		unique case (state_q)
			djs_pkg::S_DV_INIT: begin
				res_q <= op_anchor_q;
				dvd_q <= now_q - op_anchor_q;
				rem_q <= '0;
			end
			djs_pkg::S_DV_RUN: begin
				rem_q <= rem_sh[63:0];
				dvd_q <= {dvd_q[62:0], 1'b0};
			end
			// base = now minus remainder, never above now
			djs_pkg::S_DV_FIN1: res_q <= now_q - rem_q;
			djs_pkg::S_DV_FIN2: res_q <= sum_w[64] ? now_q : sum_w[63:0];
			djs_pkg::S_QY_CK: begin
				if (idx_q == '0 || cur.deadline < best_q) begin
					best_q <= cur.deadline;
				end
			end
			default: begin
			end
		endcase
		if (emit) begin
			status_q <= em_status;
			okey_q   <= em_event ? cur.key : '0;
			oown_q   <= em_event ? cur.owner : '0;
			oev_q    <= em_event ? cur.ev : '0;
			oprio_q  <= em_event ? cur.prio : '0;
			ogen_q   <= em_event ? cur.gen : '0;
			otime_q  <= em_time;
			ocnt_q   <= (em_status == djs_pkg::STS_DONE) ? posted_q : '0;
			olast_q  <= em_last;
		end
	end

	assign busy           = (state_q != djs_pkg::S_IDLE);
	assign result_valid   = result_valid_q;
	assign status         = status_q;
	assign out_job_key    = okey_q;
	assign out_owner      = oown_q;
	assign out_event_code = oev_q;
	assign out_prio       = oprio_q;
	assign out_gen_tag    = ogen_q;
	assign out_time       = otime_q;
	assign posted_count   = ocnt_q;
	assign last           = olast_q;

`ifndef SYNTHESIS
	// the final beat of a command frees the block in the same cycle
	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last |-> !busy)
		else $error("busy still high on final beat");

	// the fill count never passes the table depth
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= DepthC)
		else $error("fill count beyond table depth");

	// a dispatch never posts more than the capped limit
	a_posted_cap: assert property (@(posedge clk) disable iff (!arst_n)
		posted_q <= 5'(djs_pkg::LimitCap))
		else $error("posted count beyond cap");

	// an accepted command always makes the block busy next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("command accepted without going busy");
`endif

endmodule

// ===== rtl/djs_ram.sv =====
// ----------------------------------------------------------------------------
// djs_ram: generic single-write single-read ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module djs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: deadline job scheduler unit
// directed table of commands (empty table, duplicates, bad period, deadline
// overflow, pending and miss handling, limit saturation, unused kinds), then
// random command streams over a small key pool so the table fills, drains
// and re-posts; every result beat is checked against an in-bench job table
// ----------------------------------------------------------------------------
module testbench;

	localparam int Depth = 16;

	// one command beat
	typedef struct {
		logic [2:0]  kind;
		logic [15:0] job_key;
		logic [31:0] owner;
		logic [15:0] event_code;
		logic [63:0] time_value;
		logic [63:0] period;
		logic [31:0] gen_tag;
		logic [1:0]  miss_rule;
		logic [1:0]  prio;
		logic [63:0] now_time;
		logic [4:0]  event_limit;
	} cmd_t;

	// one result beat
	typedef struct {
		logic [3:0]  st;
		logic [15:0] key;
		logic [31:0] own;
		logic [15:0] ev;
		logic [1:0]  pr;
		logic [31:0] gen;
		logic [63:0] tm;
		logic [4:0]  cnt;
		logic        lst;
	} beat_t;

	// directed row: typed flag means st/tm are written in by hand
	typedef struct {
		cmd_t             c;
		bit               typed;
		djs_pkg::status_t st;
		logic [63:0]      tm;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [2:0]  kind = '0;
	logic [15:0] job_key = '0;
	logic [31:0] owner = '0;
	logic [15:0] event_code = '0;
	logic [63:0] time_value = '0;
	logic [63:0] period = '0;
	logic [31:0] gen_tag = '0;
	logic [1:0]  miss_rule = '0;
	logic [1:0]  prio = '0;
	logic [63:0] now_time = '0;
	logic [4:0]  event_limit = '0;
	logic        result_valid;
	logic [3:0]  status;
	logic [15:0] out_job_key;
	logic [31:0] out_owner;
	logic [15:0] out_event_code;
	logic [1:0]  out_prio;
	logic [31:0] out_gen_tag;
	logic [63:0] out_time;
	logic [4:0]  posted_count;
	logic        last;

	// job table mirror and the beats still owed by the block
	djs_pkg::entry_t jobs[Depth];
	int unsigned     job_fill;
	beat_t           owed_beats[$];
	int              err_count;
	int              cmds_sent;
	int              beats_seen;
	int              events_seen;
	logic [63:0]     clock_now;

	always #5 clk = ~clk;

	deadline_job_scheduler_unit dut (.*);

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		err_count++;
	endtask

	// next anchored deadline after now, or now when the sum wraps
	function automatic logic [63:0] next_due(logic [63:0] anc, logic [63:0] per,
		logic [63:0] now);
		logic [63:0] base;
		logic [64:0] sum;
		if (per == 0 || anc > now)
			return anc;
		base = anc + ((now - anc) / per) * per;
		sum = {1'b0, base} + {1'b0, per};
		if (sum[64])
			return now;
		return sum[63:0];
	endfunction

	function automatic beat_t plain_beat(djs_pkg::status_t st, logic lst);
		beat_t b;
		b = '{default: '0};
		b.st = st;
		b.lst = lst;
		return b;
	endfunction

	function automatic int slot_of_key(logic [15:0] key);
		for (int i = 0; i < job_fill; i++)
			if (jobs[i].key == key)
				return i;
		return -1;
	endfunction

	function automatic void drop_job(int idx);
		for (int j = idx; j + 1 < job_fill; j++)
			jobs[j] = jobs[j + 1];
		job_fill--;
	endfunction

	// works out the beats one command causes and updates the mirror
	function automatic void schedule_cmd(cmd_t c);
		djs_pkg::status_t st;
		int               idx;
		int unsigned      posted;
		int unsigned      lim;
		int unsigned      i;
		logic [63:0]      best;
		beat_t            b;
		case (c.kind)
			djs_pkg::KIND_ADD_ONE, djs_pkg::KIND_ADD_PER: begin
				st = djs_pkg::STS_OK;
				if (c.kind == djs_pkg::KIND_ADD_PER && c.period == 0)
					st = djs_pkg::STS_BAD_PER;
				else if (job_fill >= Depth)
					st = djs_pkg::STS_FULL;
				else if (slot_of_key(c.job_key) >= 0)
					st = djs_pkg::STS_DUP;
				if (st == djs_pkg::STS_OK) begin
					jobs[job_fill] = '{key: c.job_key, owner: c.owner, ev: c.event_code,
						deadline: c.time_value, anchor: c.time_value, period: '0,
						gen: c.gen_tag, miss: djs_pkg::MISS_SKIP, prio: c.prio,
						pending: 1'b0};
					if (c.kind == djs_pkg::KIND_ADD_PER) begin
						jobs[job_fill].period = c.period;
						jobs[job_fill].miss = c.miss_rule;
						jobs[job_fill].deadline = next_due(c.time_value, c.period, c.now_time);
					end
					job_fill++;
				end
				owed_beats.push_back(plain_beat(st, 1'b1));
			end
			djs_pkg::KIND_CANCEL: begin
				st = djs_pkg::STS_NOT_FOUND;
				idx = slot_of_key(c.job_key);
				if (idx >= 0 && jobs[idx].gen == c.gen_tag) begin
					drop_job(idx);
					st = djs_pkg::STS_CANCELLED;
				end
				owed_beats.push_back(plain_beat(st, 1'b1));
			end
			djs_pkg::KIND_DISPATCH: begin
				posted = 0;
				lim = (c.event_limit > djs_pkg::LimitCap) ? djs_pkg::LimitCap : c.event_limit;
				i = 0;
				while (i < job_fill && posted < lim) begin
					if (jobs[i].deadline > c.now_time) begin
						i++;
						continue;
					end
					if (jobs[i].pending) begin
						// signal-once and owner rules leave a missed job alone
						if (jobs[i].miss != djs_pkg::MISS_SKIP) begin
							i++;
							continue;
						end
						// a missed one-shot job is dropped silently
						if (jobs[i].period == 0) begin
							drop_job(i);
							continue;
						end
						jobs[i].deadline = next_due(jobs[i].anchor, jobs[i].period,
							c.now_time);
					end
					b = plain_beat(djs_pkg::STS_EVENT, 1'b0);
					b.key = jobs[i].key;
					b.own = jobs[i].owner;
					b.ev = jobs[i].ev;
					b.pr = jobs[i].prio;
					b.gen = jobs[i].gen;
					b.tm = c.now_time;
					owed_beats.push_back(b);
					posted++;
					jobs[i].pending = 1'b1;
					if (jobs[i].period != 0)
						jobs[i].deadline = next_due(jobs[i].anchor, jobs[i].period,
							c.now_time);
					i++;
				end
				b = plain_beat(djs_pkg::STS_DONE, 1'b1);
				b.cnt = 5'(posted);
				owed_beats.push_back(b);
			end
			djs_pkg::KIND_QUERY: begin
				if (job_fill == 0) begin
					owed_beats.push_back(plain_beat(djs_pkg::STS_EMPTY, 1'b1));
				end else begin
					best = jobs[0].deadline;
					for (int k = 1; k < job_fill; k++)
						if (jobs[k].deadline < best)
							best = jobs[k].deadline;
					b = plain_beat(djs_pkg::STS_DEADLINE, 1'b1);
					b.tm = best;
					owed_beats.push_back(b);
				end
			end
			default: ;
		endcase
	endfunction

	// put one command on the pins and hold it until the block takes it
	task automatic send_cmd(cmd_t c);
		kind <= c.kind;
		job_key <= c.job_key;
		owner <= c.owner;
		event_code <= c.event_code;
		time_value <= c.time_value;
		period <= c.period;
		gen_tag <= c.gen_tag;
		miss_rule <= c.miss_rule;
		prio <= c.prio;
		now_time <= c.now_time;
		event_limit <= c.event_limit;
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy);
		schedule_cmd(c);
		cmds_sent++;
	endtask

	// random gap after a beat, pct chance of idling
	task automatic maybe_idle(int pct);
		if ($urandom_range(99) < pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 9))
				@(posedge clk);
		end
	endtask

	function automatic cmd_t mk(logic [2:0] k, logic [15:0] key, logic [63:0] tv,
		logic [63:0] per, logic [63:0] now, logic [4:0] lim, logic [31:0] gen,
		logic [1:0] miss, logic [1:0] pr);
		cmd_t c;
		c = '{kind: k, job_key: key, owner: {key, ~key}, event_code: key ^ 16'h5a5a,
			time_value: tv, period: per, gen_tag: gen, miss_rule: miss, prio: pr,
			now_time: now, event_limit: lim};
		return c;
	endfunction

	// random command: mostly a small key pool and a slowly moving clock
	function automatic cmd_t rand_cmd();
		cmd_t        c;
		int unsigned pick;
		int          idx;
		pick = $urandom_range(99);
		c.owner = $urandom;
		c.event_code = 16'($urandom);
		c.miss_rule = 2'($urandom_range(3));
		c.prio = 2'($urandom_range(3));
		c.event_limit = ($urandom_range(3) == 0) ? 5'($urandom_range(31))
			: 5'($urandom_range(1, 16));
		c.job_key = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(23));
		c.gen_tag = ($urandom_range(9) == 0) ? $urandom : $urandom_range(3);
		if ($urandom_range(19) == 0)
			clock_now = {$urandom, $urandom};
		else
			clock_now = clock_now + 64'($urandom_range(0, 120));
		c.now_time = clock_now;
		c.time_value = ($urandom_range(9) == 0) ? {$urandom, $urandom}
			: clock_now + 64'($urandom_range(0, 300)) - 64'd60;
		c.period = ($urandom_range(9) == 0) ? {$urandom, $urandom}
			: 64'($urandom_range(0, 200));
		if (pick < 25)
			c.kind = djs_pkg::KIND_ADD_ONE;
		else if (pick < 45)
			c.kind = djs_pkg::KIND_ADD_PER;
		else if (pick < 60)
			c.kind = djs_pkg::KIND_CANCEL;
		else if (pick < 88)
			c.kind = djs_pkg::KIND_DISPATCH;
		else if (pick < 96)
			c.kind = djs_pkg::KIND_QUERY;
		else
			c.kind = 3'($urandom_range(5, 7));
		// most cancels name a live job with its own generation
		if (c.kind == djs_pkg::KIND_CANCEL && job_fill > 0 && $urandom_range(3) != 0) begin
			idx = $urandom_range(job_fill - 1);
			c.job_key = jobs[idx].key;
			if ($urandom_range(4) != 0)
				c.gen_tag = jobs[idx].gen;
		end
		return c;
	endfunction

	// every strobed beat must match the oldest owed beat
	always @(posedge clk) begin
		beat_t w;
		if (arst_n && result_valid) begin
			beats_seen++;
			if (status == djs_pkg::STS_EVENT)
				events_seen++;
			if (owed_beats.size() == 0) begin
				report("unexpected beat, status", 64'(status), '0);
			end else begin
				w = owed_beats.pop_front();
				if (status !== w.st) report("status", 64'(status), 64'(w.st));
				if (out_job_key !== w.key)
					report("out_job_key", 64'(out_job_key), 64'(w.key));
				if (out_owner !== w.own) report("out_owner", 64'(out_owner), 64'(w.own));
				if (out_event_code !== w.ev)
					report("out_event_code", 64'(out_event_code), 64'(w.ev));
				if (out_prio !== w.pr) report("out_prio", 64'(out_prio), 64'(w.pr));
				if (out_gen_tag !== w.gen)
					report("out_gen_tag", 64'(out_gen_tag), 64'(w.gen));
				if (out_time !== w.tm) report("out_time", out_time, w.tm);
				if (posted_count !== w.cnt)
					report("posted_count", 64'(posted_count), 64'(w.cnt));
				if (last !== w.lst) report("last", 64'(last), 64'(w.lst));
			end
		end
	end

	// hard stop well past the slowest legal run
	initial begin
		#20_000_000;
		$display("testbench: done, errors");
		$finish;
	end

	initial begin
		row_t        rows[$];
		int          idle_pct[3];
		logic [63:0] top;
		idle_pct = '{0, 77, 22};
		top = '1;
		job_fill = 0;
		err_count = 0;
		cmds_sent = 0;
		beats_seen = 0;
		events_seen = 0;
		clock_now = 64'd500;

		// empty table, duplicate id, zero period, field extremes
		rows.push_back('{mk(djs_pkg::KIND_QUERY, 0, 0, 0, 0, 0, 0, 0, 0), 1,
			djs_pkg::STS_EMPTY, 0});
		rows.push_back('{mk(djs_pkg::KIND_ADD_ONE, 0, 0, 0, 0, 0, 0, 0, 0), 1,
			djs_pkg::STS_OK, 0});
		rows.push_back('{mk(djs_pkg::KIND_ADD_ONE, 0, 5, 0, 0, 0, 1, 0, 1), 1,
			djs_pkg::STS_DUP, 0});
		rows.push_back('{mk(djs_pkg::KIND_ADD_PER, 1, 9, 0, 9, 0, 0, 0, 0), 1,
			djs_pkg::STS_BAD_PER, 0});
		rows.push_back('{mk(djs_pkg::KIND_ADD_ONE, 16'hffff, top, top, top, 5'h1f, '1, 3, 3),
			1, djs_pkg::STS_OK, 0});
		rows.push_back('{mk(djs_pkg::KIND_ADD_PER, 2, 100, 30, 250, 0, 7, 0, 1), 1,
			djs_pkg::STS_OK, 0});
		// anchor plus period wraps past the top, deadline falls back to now
		rows.push_back('{mk(djs_pkg::KIND_ADD_PER, 3, top - 15, 64'h8000_0000_0000_0000, top,
			0, 3, 1, 2), 1, djs_pkg::STS_OK, 0});
		// anchor still ahead of now
		rows.push_back('{mk(djs_pkg::KIND_ADD_PER, 4, 1000, 7, 5, 0, 4, 2, 2), 1,
			djs_pkg::STS_OK, 0});
		rows.push_back('{mk(djs_pkg::KIND_QUERY, 0, 0, 0, 0, 0, 0, 0, 0), 1,
			djs_pkg::STS_DEADLINE, 0});
		// limit above sixteen saturates
		rows.push_back('{mk(djs_pkg::KIND_DISPATCH, 0, 0, 0, 300, 31, 0, 0, 0), 0,
			djs_pkg::STS_OK, 0});
		// pending one-shot dropped
		rows.push_back('{mk(djs_pkg::KIND_DISPATCH, 0, 0, 0, 300, 20, 0, 0, 0), 0,
			djs_pkg::STS_OK, 0});
		rows.push_back('{mk(djs_pkg::KIND_DISPATCH, 0, 0, 0, top, 0, 0, 0, 0), 0,
			djs_pkg::STS_OK, 0});
		rows.push_back('{mk(djs_pkg::KIND_DISPATCH, 0, 0, 0, top, 1, 0, 0, 0), 0,
			djs_pkg::STS_OK, 0});
		rows.push_back('{mk(djs_pkg::KIND_CANCEL, 2, 0, 0, 0, 0, 5, 0, 0), 1,
			djs_pkg::STS_NOT_FOUND, 0});
		rows.push_back('{mk(djs_pkg::KIND_CANCEL, 9, 0, 0, 0, 0, 0, 0, 0), 1,
			djs_pkg::STS_NOT_FOUND, 0});
		rows.push_back('{mk(djs_pkg::KIND_CANCEL, 16'hffff, 0, 0, 0, 0, '1, 0, 0), 0,
			djs_pkg::STS_OK, 0});
		// unused kinds give no beat
		rows.push_back('{mk(3'd5, 7, top, top, top, 5'h1f, '1, 3, 3), 0, djs_pkg::STS_OK, 0});
		rows.push_back('{mk(3'd6, 7, 0, 1, 0, 1, 0, 0, 0), 0, djs_pkg::STS_OK, 0});
		rows.push_back('{mk(3'd7, 7, 0, 1, 0, 1, 0, 0, 0), 0, djs_pkg::STS_OK, 0});
		// unused miss code behaves like signal once
		rows.push_back('{mk(djs_pkg::KIND_ADD_PER, 5, 0, 1, 0, 0, 9, 3, 0), 0,
			djs_pkg::STS_OK, 0});
		rows.push_back('{mk(djs_pkg::KIND_DISPATCH, 0, 0, 0, top, 16, 0, 0, 0), 0,
			djs_pkg::STS_OK, 0});
		rows.push_back('{mk(djs_pkg::KIND_DISPATCH, 0, 0, 0, top, 16, 0, 0, 0), 0,
			djs_pkg::STS_OK, 0});
		rows.push_back('{mk(djs_pkg::KIND_QUERY, 0, 0, 0, 0, 0, 0, 0, 0), 0,
			djs_pkg::STS_OK, 0});

		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[r]) begin
			send_cmd(rows[r].c);
			// hand-typed rows owe exactly one beat, overwrite what the mirror said
			if (rows[r].typed) begin
				owed_beats[owed_beats.size() - 1].st = rows[r].st;
				owed_beats[owed_beats.size() - 1].tm = rows[r].tm;
			end
		end

		// random phases: no idling, heavy idling, light idling
		for (int ph = 0; ph < 3; ph++) begin
			repeat (49) begin
				send_cmd(rand_cmd());
				maybe_idle(idle_pct[ph]);
			end
			// sender holds off until the block has paid every beat
			start <= 1'b0;
			wait (owed_beats.size() == 0);
			@(posedge clk);
		end

		start <= 1'b0;
		wait (owed_beats.size() == 0);
		repeat (200)
			@(posedge clk);
		$display("covered %0d commands, %0d result beats, %0d posted events",
			cmds_sent, beats_seen, events_seen);
		$display("mismatches %0d, jobs left in table %0d", err_count, job_fill);
		if (err_count == 0 && owed_beats.size() == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
